// ----- src/v3alu_pkg.sv -----
// v3alu_pkg: shared types, opcodes and constants of the 3d vector alu
// no dependencies

package v3alu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;

    typedef enum logic [3:0] {
        OP_NEG      = 4'd0,
        OP_PERP     = 4'd1,
        OP_SCALE    = 4'd2,
        OP_DIV      = 4'd3,
        OP_ADD      = 4'd4,
        OP_SUB      = 4'd5,
        OP_DOT      = 4'd6,
        OP_PERPPROD = 4'd7,
        OP_CROSS    = 4'd8,
        OP_NORM     = 4'd9
    } opcode_t;

    localparam logic [1:0] DIM_PLANE = 2'd2;
    localparam logic [1:0] DIM_CROSS = 2'd3;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by_comp;
        logic signed [31:0] bz;
        logic signed [31:0] scalar_in;
        logic [1:0]         dim_a;
        logic [1:0]         dim_b;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic [1:0]         rdim;
        logic signed [31:0] scalar_out;
        logic               dim_error;
        logic               overflow;
        logic               div_zero;
    } out_item_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [95:0] v,
                                                  output logic ovf);
        logic signed [95:0] hi_lim;
        logic signed [95:0] lo_lim;
        hi_lim = 96'sh7FFFFFFF;
        lo_lim = -96'sh80000000;
        ovf = 1'b0;
        if (v > hi_lim)
        begin
            ovf = 1'b1;
            sat32 = 32'sh7FFFFFFF;
        end
        else if (v < lo_lim)
        begin
            ovf = 1'b1;
            sat32 = 32'sh80000000;
        end
        else
        begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

// ----- src/v3alu_pipe.sv -----
// v3alu_pipe: stalling pipeline of a W-bit payload with valid bits, used for the item lines
// depends on nothing

module v3alu_pipe #(
    parameter int W     = 8,
    parameter int DEPTH = 3
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    output logic [W-1:0] out_data
);

    logic [DEPTH-1:0] vld_reg;
    logic [W-1:0]     dat_reg [DEPTH];

    // valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // data shift line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dat_reg[0] <= in_data;
            for (int i = 1; i < DEPTH; i++)
                dat_reg[i] <= dat_reg[i-1];
        end
    end

    assign out_valid = vld_reg[DEPTH-1];
    assign out_data  = dat_reg[DEPTH-1];

endmodule

// ----- src/v3alu_div.sv -----
// v3alu_div: pipelined restoring divider, one quotient bit per stage
// depends on nothing

module v3alu_div #(
    parameter int NW = 56,
    parameter int DW = 33
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [NW-1:0] quo
);

    logic [DW:0]   rem_reg [NW-1];
    logic [NW-1:0] q_reg   [NW];
    logic [NW-1:0] n_reg   [NW-1];
    logic [DW-1:0] d_reg   [NW-1];

    logic [DW:0]   rem_in  [NW];
    logic [NW-1:0] q_in    [NW];
    logic [NW-1:0] n_in    [NW];
    logic [DW-1:0] d_in    [NW];
    logic [DW:0]   trial   [NW];
    logic          fit     [NW];
    logic [DW:0]   diff    [NW];

    // stage inputs and trial subtraction, msb first
    always_comb
    begin
        rem_in[0] = '0;
        q_in[0]   = '0;
        n_in[0]   = num;
        d_in[0]   = den;
        for (int s = 1; s < NW; s++)
        begin
            rem_in[s] = rem_reg[s-1];
            q_in[s]   = q_reg[s-1];
            n_in[s]   = n_reg[s-1];
            d_in[s]   = d_reg[s-1];
        end
        for (int s = 0; s < NW; s++)
        begin
            trial[s] = {rem_in[s][DW-1:0], n_in[s][NW-1-s]};
            fit[s]   = (trial[s] >= {1'b0, d_in[s]});
            diff[s]  = fit[s] ? (trial[s] - {1'b0, d_in[s]}) : trial[s];
        end
    end

    // one bit of quotient per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NW; s++)
                q_reg[s] <= fit[s] ? (q_in[s] | (NW'(1) << (NW-1-s))) : q_in[s];
            for (int s = 0; s < NW - 1; s++)
            begin
                rem_reg[s] <= diff[s];
                n_reg[s]   <= n_in[s];
                d_reg[s]   <= d_in[s];
            end
        end
    end

    assign quo = q_reg[NW-1];

endmodule

// ----- src/v3alu_sqrt.sv -----
// v3alu_sqrt: pipelined integer square root, one result bit per stage
// depends on nothing

module v3alu_sqrt #(
    parameter int VW = 66
) (
    input  logic          clk,
    input  logic          en,
    input  logic [VW-1:0] val,
    output logic [VW/2-1:0] root
);

    localparam int RW = VW / 2;

    logic [VW-1:0] v_reg   [RW-1];
    logic [RW+1:0] r_reg   [RW];
    logic [RW+1:0] rem_reg [RW-1];

    logic [VW-1:0] v_in    [RW];
    logic [RW+1:0] r_in    [RW];
    logic [RW+1:0] rem_in  [RW];
    logic [RW+1:0] trial   [RW];
    logic [RW+1:0] test    [RW];

    // stage inputs, two radicand bits per stage
    always_comb
    begin
        v_in[0]   = val;
        r_in[0]   = '0;
        rem_in[0] = '0;
        for (int s = 1; s < RW; s++)
        begin
            v_in[s]   = v_reg[s-1];
            r_in[s]   = r_reg[s-1];
            rem_in[s] = rem_reg[s-1];
        end
        for (int s = 0; s < RW; s++)
        begin
            trial[s] = {rem_in[s][RW-1:0], v_in[s][VW-1-2*s -: 2]};
            test[s]  = {r_in[s][RW-1:0], 2'b01};
        end
    end

    // digit-by-digit root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < RW; s++)
                r_reg[s] <= {r_in[s][RW:0], (trial[s] >= test[s])};
            for (int s = 0; s < RW - 1; s++)
            begin
                v_reg[s]   <= v_in[s];
                rem_reg[s] <= (trial[s] >= test[s]) ? (trial[s] - test[s]) : trial[s];
            end
        end
    end

    assign root = r_reg[RW-1][RW-1:0];

endmodule

// ----- src/vector3_alu_top.sv -----
// vector3_alu_top: fixed-point 3d vector alu, fully pipelined
// depends on v3alu_pkg, v3alu_pipe, v3alu_div, v3alu_sqrt

// Usage
//   in channel  : in_valid / in_ready / in_data (v3alu_pkg::in_item_t)
//   out channel : out_valid / out_ready / out_data (v3alu_pkg::out_item_t)
//   one result transaction per input transaction, in order.
//   stages: the accepting edge fills the product stage, then come the
//   sum stage, 34 square root stages, 32 + FRAC_BITS divider stages and
//   the output register.
//   throughput: one transaction per cycle while the output is not
//   stalled; every stage is registered.
//   the whole pipeline advances when the output register is empty or
//   taken, so a stalled receiver freezes it and nothing is lost.
//   in_ready falls only while the output holds an untaken result.
//   reset clears all valid bits; payload registers are not reset.
//   operations: neg, perp, scale, div, add, sub, dot, perpprod, cross,
//   normalize; results saturate to 32 bits and set overflow.

module vector3_alu_top #(
    parameter int FRAC_BITS = v3alu_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  v3alu_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output v3alu_pkg::out_item_t out_data
);

    localparam int NW   = 32 + FRAC_BITS;      // dividend magnitude width
    localparam int DW   = 34;                  // divisor magnitude width
    localparam int SQW  = 68;                  // radicand width
    localparam int SQD  = SQW / 2;             // sqrt stages
    localparam int LAT_DIV = SQD + NW + 3;     // in -> div result stage
    localparam int IW   = $bits(v3alu_pkg::in_item_t);

    logic en;
    logic out_valid_reg;
    v3alu_pkg::out_item_t out_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ---------------- stage 1: products and squares
    v3alu_pkg::in_item_t s1_reg;
    logic                s1_v_reg;
    logic signed [63:0]  p_reg [9];
    logic [63:0]         sq_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_v_reg <= 1'b0;
        else if (en)
            s1_v_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg   <= in_data;
            p_reg[0] <= in_data.ax * in_data.scalar_in;
            p_reg[1] <= in_data.ay * in_data.scalar_in;
            p_reg[2] <= in_data.az * in_data.scalar_in;
            p_reg[3] <= in_data.ax * in_data.bx;
            p_reg[4] <= in_data.ay * in_data.by_comp;
            p_reg[5] <= in_data.az * in_data.bz;
            p_reg[6] <= in_data.ay * in_data.bx;
            p_reg[7] <= in_data.az * in_data.by_comp;
            p_reg[8] <= in_data.ax * in_data.bz;
            sq_reg[0] <= in_data.ax * in_data.ax;
            sq_reg[1] <= in_data.ay * in_data.ay;
            sq_reg[2] <= in_data.az * in_data.az;
        end
    end

    // ---------------- stage 2: dot sum, radicand
    logic signed [65:0] sum_reg;
    logic [SQW-1:0]     rad_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= 66'(p_reg[3]) + 66'(p_reg[4]) + 66'(p_reg[5]);
            rad_reg <= SQW'(sq_reg[0]) + SQW'(sq_reg[1]) + SQW'(sq_reg[2]);
        end
    end

    // perp product and cross terms need by*ax etc.; form second set of products
    logic signed [63:0] q_reg [3];   // ax*by, az*bx, ay*bz
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg[0] <= s1_reg.ax * s1_reg.by_comp;
            q_reg[1] <= s1_reg.az * s1_reg.bx;
            q_reg[2] <= s1_reg.ay * s1_reg.bz;
        end
    end

    // stage 3: cross and perp sums, dot sum and scale products carried along
    logic signed [65:0] cr_reg [3];
    logic signed [65:0] dot_reg;
    logic signed [63:0] sc_reg [3];
    v3alu_pkg::in_item_t s2_reg, s3_reg;
    logic s2_v_reg, s3_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
        end
    end

    logic signed [63:0] p2_reg [9];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            p2_reg <= p_reg;
            cr_reg[0] <= 66'(q_reg[2]) - 66'(p2_reg[7]);
            cr_reg[1] <= 66'(q_reg[1]) - 66'(p2_reg[8]);
            cr_reg[2] <= 66'(q_reg[0]) - 66'(p2_reg[6]);
            dot_reg   <= sum_reg;
            sc_reg[0] <= p2_reg[0];
            sc_reg[1] <= p2_reg[1];
            sc_reg[2] <= p2_reg[2];
        end
    end

    // ---------------- non-divide result at stage 4
    function automatic logic signed [31:0] shf(input logic signed [65:0] v,
                                                input int fb, output logic ovf);
        logic signed [95:0] w;
        w = 96'(v) >>> fb;
        shf = v3alu_pkg::sat32(w, ovf);
    endfunction

    v3alu_pkg::out_item_t r4_next;
    always_comb
    begin
        logic o0, o1, o2, o3;
        logic signed [95:0] t0, t1, t2;
        r4_next = '0;
        o0 = 1'b0; o1 = 1'b0; o2 = 1'b0; o3 = 1'b0;
        t0 = '0; t1 = '0; t2 = '0;
        case (s3_reg.opcode)
            v3alu_pkg::OP_NEG:
            begin
                t0 = -96'(s3_reg.ax); t1 = -96'(s3_reg.ay); t2 = -96'(s3_reg.az);
                r4_next.rx = v3alu_pkg::sat32(t0, o0);
                r4_next.ry = v3alu_pkg::sat32(t1, o1);
                r4_next.rz = v3alu_pkg::sat32(t2, o2);
                r4_next.rdim = s3_reg.dim_a;
            end
            v3alu_pkg::OP_PERP:
            begin
                t0 = -96'(s3_reg.ay);
                r4_next.rx = v3alu_pkg::sat32(t0, o0);
                r4_next.ry = s3_reg.ax;
                r4_next.rz = s3_reg.az;
                r4_next.rdim = s3_reg.dim_a;
                r4_next.dim_error = (s3_reg.dim_a != v3alu_pkg::DIM_PLANE);
            end
            v3alu_pkg::OP_SCALE:
            begin
                r4_next.rx = shf(66'(sc_reg[0]), FRAC_BITS, o0);
                r4_next.ry = shf(66'(sc_reg[1]), FRAC_BITS, o1);
                r4_next.rz = shf(66'(sc_reg[2]), FRAC_BITS, o2);
                r4_next.rdim = s3_reg.dim_a;
            end
            v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB:
            begin
                if (s3_reg.opcode == v3alu_pkg::OP_ADD)
                begin
                    t0 = 96'(s3_reg.ax) + 96'(s3_reg.bx);
                    t1 = 96'(s3_reg.ay) + 96'(s3_reg.by_comp);
                    t2 = 96'(s3_reg.az) + 96'(s3_reg.bz);
                end
                else
                begin
                    t0 = 96'(s3_reg.ax) - 96'(s3_reg.bx);
                    t1 = 96'(s3_reg.ay) - 96'(s3_reg.by_comp);
                    t2 = 96'(s3_reg.az) - 96'(s3_reg.bz);
                end
                r4_next.rx = v3alu_pkg::sat32(t0, o0);
                r4_next.ry = v3alu_pkg::sat32(t1, o1);
                r4_next.rz = v3alu_pkg::sat32(t2, o2);
                r4_next.rdim = (s3_reg.dim_a > s3_reg.dim_b) ? s3_reg.dim_a
                                                              : s3_reg.dim_b;
            end
            v3alu_pkg::OP_DOT:
                r4_next.scalar_out = shf(dot_reg, FRAC_BITS, o3);
            v3alu_pkg::OP_PERPPROD:
            begin
                r4_next.scalar_out = shf(cr_reg[2], FRAC_BITS, o3);
                r4_next.dim_error = (s3_reg.dim_a != v3alu_pkg::DIM_PLANE);
            end
            v3alu_pkg::OP_CROSS:
            begin
                r4_next.rx = shf(cr_reg[0], FRAC_BITS, o0);
                r4_next.ry = shf(cr_reg[1], FRAC_BITS, o1);
                r4_next.rz = shf(cr_reg[2], FRAC_BITS, o2);
                r4_next.rdim = v3alu_pkg::DIM_CROSS;
            end
            default: r4_next = '0;
        endcase
        r4_next.overflow = o0 | o1 | o2 | o3;
    end

    // ---------------- divide / normalize path
    // sqrt on radicand (from stage 2), then divide |a|<<F by den
    logic [SQD-1:0] root;
    v3alu_sqrt #(.VW(SQW)) u_sqrt (
        .clk(clk), .en(en), .val(rad_reg), .root(root)
    );

    // item delayed to line up with root (stage 2 + SQD)
    logic [IW-1:0] dq_data;
    logic          dq_v;
    v3alu_pipe #(.W(IW), .DEPTH(SQD)) u_sq_line (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_v_reg),
        .in_data(s2_reg), .out_valid(dq_v), .out_data(dq_data)
    );

    v3alu_pkg::in_item_t dq;
    logic [DW-1:0] den;
    logic [NW-1:0] n0, n1, n2;
    assign dq = v3alu_pkg::in_item_t'(dq_data);
    always_comb
    begin
        if (dq.opcode == v3alu_pkg::OP_NORM)
            den = DW'(root);
        else
            den = dq.scalar_in[31] ? DW'(-34'(dq.scalar_in)) : DW'(dq.scalar_in);
        n0 = NW'(dq.ax[31] ? -33'(dq.ax) : 33'(dq.ax)) << FRAC_BITS;
        n1 = NW'(dq.ay[31] ? -33'(dq.ay) : 33'(dq.ay)) << FRAC_BITS;
        n2 = NW'(dq.az[31] ? -33'(dq.az) : 33'(dq.az)) << FRAC_BITS;
    end

    logic [NW-1:0] qx, qy, qz;
    v3alu_div #(.NW(NW), .DW(DW)) u_dx (.clk(clk), .en(en), .num(n0), .den(den), .quo(qx));
    v3alu_div #(.NW(NW), .DW(DW)) u_dy (.clk(clk), .en(en), .num(n1), .den(den), .quo(qy));
    v3alu_div #(.NW(NW), .DW(DW)) u_dz (.clk(clk), .en(en), .num(n2), .den(den), .quo(qz));

    logic [IW+DW-1:0] dv_data;
    logic             dv_v;
    v3alu_pipe #(.W(IW + DW), .DEPTH(NW)) u_dv_line (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(dq_v),
        .in_data({dq_data, den}), .out_valid(dv_v), .out_data(dv_data)
    );

    v3alu_pkg::in_item_t dv;
    logic [DW-1:0] dv_den;
    assign dv = v3alu_pkg::in_item_t'(dv_data[IW+DW-1:DW]);
    assign dv_den = dv_data[DW-1:0];

    // signed quotient and saturation
    function automatic logic signed [31:0] qsat(input logic [NW-1:0] q,
                                                 input logic neg, output logic ovf);
        logic signed [95:0] w;
        w = neg ? -96'(q) : 96'(q);
        qsat = v3alu_pkg::sat32(w, ovf);
    endfunction

    function automatic logic signed [31:0] dz_val(input logic signed [31:0] a);
        if (a > 0)
            dz_val = 32'sh7FFFFFFF;
        else if (a < 0)
            dz_val = 32'sh80000000;
        else
            dz_val = '0;
    endfunction

    v3alu_pkg::out_item_t rd_next;
    always_comb
    begin
        logic o0, o1, o2, sn;
        rd_next = '0;
        o0 = 1'b0; o1 = 1'b0; o2 = 1'b0;
        sn = (dv.opcode == v3alu_pkg::OP_DIV) ? dv.scalar_in[31] : 1'b0;
        if (dv.opcode == v3alu_pkg::OP_DIV)
        begin
            rd_next.rdim = dv.dim_a;
            if (dv.scalar_in == '0)
            begin
                rd_next.div_zero = 1'b1;
                rd_next.rx = dz_val(dv.ax);
                rd_next.ry = dz_val(dv.ay);
                rd_next.rz = dz_val(dv.az);
                rd_next.overflow = (dv.ax != '0) || (dv.ay != '0) || (dv.az != '0);
            end
            else
            begin
                rd_next.rx = qsat(qx, dv.ax[31] ^ sn, o0);
                rd_next.ry = qsat(qy, dv.ay[31] ^ sn, o1);
                rd_next.rz = qsat(qz, dv.az[31] ^ sn, o2);
                rd_next.overflow = o0 | o1 | o2;
            end
        end
        else
        begin
            rd_next.rdim = v3alu_pkg::DIM_CROSS;
            if (dv_den != '0)
            begin
                rd_next.rx = qsat(qx, dv.ax[31], o0);
                rd_next.ry = qsat(qy, dv.ay[31], o1);
                rd_next.rz = qsat(qz, dv.az[31], o2);
                rd_next.overflow = o0 | o1 | o2;
            end
        end
    end

    // non-divide results travel down a line to join the divide path
    localparam int FILL = LAT_DIV - 4;
    logic [$bits(v3alu_pkg::out_item_t)-1:0] fr_data;
    logic fr_v;
    v3alu_pipe #(.W($bits(v3alu_pkg::out_item_t)), .DEPTH(FILL)) u_fast_line (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s3_v_reg),
        .in_data(r4_next), .out_valid(fr_v), .out_data(fr_data)
    );

    // ---------------- output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dv.opcode == v3alu_pkg::OP_DIV || dv.opcode == v3alu_pkg::OP_NORM)
                out_reg <= rd_next;
            else
                out_reg <= v3alu_pkg::out_item_t'(fr_data);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef NO_ASSERTIONS
    // the divide and fast paths are valid in step
    a_paths_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        dv_v == fr_v) else $error("divide and fast paths out of step");
    // stalled output holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed under stall");
    // ready only low while a result waits
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid) else $error("ready low without pending result");
`endif

endmodule

// ----- tb/vector3_alu_top_tb.sv -----
// vector3_alu_top_tb: self-checking testbench for the fixed-point 3d vector alu
// depends on v3alu_pkg and vector3_alu_top; drives both channels with random idling
`timescale 1ns / 100ps

module vector3_alu_top_tb;

    localparam int FRAC = v3alu_pkg::FRAC_BITS_DEF;
    localparam logic [3:0] OP_UNDEF_LO = 4'd10;
    localparam logic [3:0] OP_UNDEF_HI = 4'd15;
    localparam logic signed [31:0] W_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] W_MIN = 32'sh80000000;
    localparam logic signed [31:0] W_ONE = 32'sh00010000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    v3alu_pkg::in_item_t  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    v3alu_pkg::out_item_t out_data;

    v3alu_pkg::out_item_t expected_q[$];
    int        fail_cnt = 0;
    bit        no_idle = 1'b0;
    int        stall_cnt = 0;

    vector3_alu_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

    // gap length: mostly short, a few long
    function automatic int gap_len();
        if (no_idle)
            return 0;
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 2);
        return $urandom_range(3, 30);
    endfunction

    // saturate to 32 bits, noting overflow
    function automatic logic signed [31:0] clamp_word(input logic signed [95:0] v,
                                                      inout bit ovf);
        logic signed [95:0] hi_lim;
        logic signed [95:0] lo_lim;
        hi_lim = W_MAX;
        lo_lim = W_MIN;
        if (v > hi_lim)
        begin
            ovf = 1'b1;
            return W_MAX;
        end
        if (v < lo_lim)
        begin
            ovf = 1'b1;
            return W_MIN;
        end
        return v[31:0];
    endfunction

    // quotient in fixed point, truncated toward zero
    function automatic logic signed [95:0] fixed_quot(input logic signed [95:0] num,
                                                      input logic signed [95:0] den);
        return (num <<< FRAC) / den;
    endfunction

    // floor of the square root
    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // expected result of one vector operation
    function automatic v3alu_pkg::out_item_t vector_result(input v3alu_pkg::in_item_t it);
        v3alu_pkg::out_item_t r;
        bit ovf;
        logic signed [95:0] a[3];
        logic signed [95:0] b[3];
        logic signed [95:0] s;
        logic signed [95:0] len_w;
        longint unsigned sq;
        longint unsigned len;
        r = '0;
        ovf = 1'b0;
        a[0] = it.ax; a[1] = it.ay; a[2] = it.az;
        b[0] = it.bx; b[1] = it.by_comp; b[2] = it.bz;
        s = it.scalar_in;
        case (it.opcode)
            v3alu_pkg::OP_NEG:
            begin
                for (int i = 0; i < 3; i++)
                    a[i] = -a[i];
                r.rx = clamp_word(a[0], ovf);
                r.ry = clamp_word(a[1], ovf);
                r.rz = clamp_word(a[2], ovf);
                r.rdim = it.dim_a;
            end
            v3alu_pkg::OP_PERP:
            begin
                r.dim_error = (it.dim_a != v3alu_pkg::DIM_PLANE);
                r.rx = clamp_word(-a[1], ovf);
                r.ry = it.ax;
                r.rz = it.az;
                r.rdim = it.dim_a;
            end
            v3alu_pkg::OP_SCALE:
            begin
                r.rx = clamp_word((a[0] * s) >>> FRAC, ovf);
                r.ry = clamp_word((a[1] * s) >>> FRAC, ovf);
                r.rz = clamp_word((a[2] * s) >>> FRAC, ovf);
                r.rdim = it.dim_a;
            end
            v3alu_pkg::OP_DIV:
            begin
                r.rdim = it.dim_a;
                if (s == 0)
                begin
                    r.div_zero = 1'b1;
                    r.rx = (a[0] > 0) ? W_MAX : ((a[0] < 0) ? W_MIN : 32'sd0);
                    r.ry = (a[1] > 0) ? W_MAX : ((a[1] < 0) ? W_MIN : 32'sd0);
                    r.rz = (a[2] > 0) ? W_MAX : ((a[2] < 0) ? W_MIN : 32'sd0);
                    ovf = (a[0] != 0) || (a[1] != 0) || (a[2] != 0);
                end
                else
                begin
                    r.rx = clamp_word(fixed_quot(a[0], s), ovf);
                    r.ry = clamp_word(fixed_quot(a[1], s), ovf);
                    r.rz = clamp_word(fixed_quot(a[2], s), ovf);
                end
            end
            v3alu_pkg::OP_ADD, v3alu_pkg::OP_SUB:
            begin
                if (it.opcode == v3alu_pkg::OP_SUB)
                    for (int i = 0; i < 3; i++)
                        b[i] = -b[i];
                r.rx = clamp_word(a[0] + b[0], ovf);
                r.ry = clamp_word(a[1] + b[1], ovf);
                r.rz = clamp_word(a[2] + b[2], ovf);
                r.rdim = (it.dim_a > it.dim_b) ? it.dim_a : it.dim_b;
            end
            v3alu_pkg::OP_DOT:
                r.scalar_out = clamp_word((a[0] * b[0] + a[1] * b[1] + a[2] * b[2])
                                          >>> FRAC, ovf);
            v3alu_pkg::OP_PERPPROD:
            begin
                r.dim_error = (it.dim_a != v3alu_pkg::DIM_PLANE);
                r.scalar_out = clamp_word((a[0] * b[1] - a[1] * b[0]) >>> FRAC, ovf);
            end
            v3alu_pkg::OP_CROSS:
            begin
                r.rx = clamp_word((a[1] * b[2] - a[2] * b[1]) >>> FRAC, ovf);
                r.ry = clamp_word((a[2] * b[0] - a[0] * b[2]) >>> FRAC, ovf);
                r.rz = clamp_word((a[0] * b[1] - a[1] * b[0]) >>> FRAC, ovf);
                r.rdim = v3alu_pkg::DIM_CROSS;
            end
            v3alu_pkg::OP_NORM:
            begin
                sq = 0;
                for (int i = 0; i < 3; i++)
                    sq = sq + 64'(a[i] * a[i]);
                len = floor_sqrt(sq);
                r.rdim = v3alu_pkg::DIM_CROSS;
                if (len != 0)
                begin
                    len_w = {32'd0, len};
                    r.rx = clamp_word(fixed_quot(a[0], len_w), ovf);
                    r.ry = clamp_word(fixed_quot(a[1], len_w), ovf);
                    r.rz = clamp_word(fixed_quot(a[2], len_w), ovf);
                end
            end
            default:
                ;
        endcase
        r.overflow = ovf;
        return r;
    endfunction

    // send one transaction and record its expected result
    task automatic send_item(input v3alu_pkg::in_item_t it);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        expected_q.push_back(vector_result(it));
    endtask

    function automatic v3alu_pkg::in_item_t make_item(input logic [3:0] op,
                                           input logic signed [31:0] ax, ay, az,
                                           input logic signed [31:0] bx, by_c, bz,
                                           input logic signed [31:0] s,
                                           input logic [1:0] da, db);
        v3alu_pkg::in_item_t it;
        it.opcode = op;
        it.ax = ax; it.ay = ay; it.az = az;
        it.bx = bx; it.by_comp = by_c; it.bz = bz;
        it.scalar_in = s;
        it.dim_a = da; it.dim_b = db;
        return it;
    endfunction

    // operand mix: extremes, zero, small and full-range values
    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 7))
            0: return W_MAX;
            1: return W_MIN;
            2: return 32'sd0;
            3: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            4: return ($signed($urandom_range(0, 64)) - 32) * W_ONE;
            default: return $urandom;
        endcase
    endfunction

    function automatic v3alu_pkg::in_item_t rand_item();
        v3alu_pkg::in_item_t it;
        it.opcode = ($urandom_range(0, 19) == 0)
                    ? 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI))
                    : 4'($urandom_range(v3alu_pkg::OP_NEG, v3alu_pkg::OP_NORM));
        it.ax = rand_word(); it.ay = rand_word(); it.az = rand_word();
        it.bx = rand_word(); it.by_comp = rand_word(); it.bz = rand_word();
        it.scalar_in = ($urandom_range(0, 9) == 0) ? 32'sd0 : rand_word();
        it.dim_a = 2'($urandom);
        it.dim_b = 2'($urandom);
        return it;
    endfunction

    task automatic report(input string field, input logic [31:0] exp_v,
                          input logic [31:0] got_v);
        $display("%0t: %s mismatch, expected %h actual %h", $realtime, field, exp_v, got_v);
        fail_cnt++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        v3alu_pkg::out_item_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected transaction, expected none actual %h",
                         $realtime, out_data);
                fail_cnt++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (out_data.rx !== exp_r.rx) report("rx", exp_r.rx, out_data.rx);
                if (out_data.ry !== exp_r.ry) report("ry", exp_r.ry, out_data.ry);
                if (out_data.rz !== exp_r.rz) report("rz", exp_r.rz, out_data.rz);
                if (out_data.rdim !== exp_r.rdim) report("rdim", exp_r.rdim, out_data.rdim);
                if (out_data.scalar_out !== exp_r.scalar_out)
                    report("scalar_out", exp_r.scalar_out, out_data.scalar_out);
                if (out_data.dim_error !== exp_r.dim_error)
                    report("dim_error", exp_r.dim_error, out_data.dim_error);
                if (out_data.overflow !== exp_r.overflow)
                    report("overflow", exp_r.overflow, out_data.overflow);
                if (out_data.div_zero !== exp_r.div_zero)
                    report("div_zero", exp_r.div_zero, out_data.div_zero);
            end
        end
    end

    // receiver stalls
    always @(posedge clk)
    begin
        if (no_idle)
            out_ready <= 1'b1;
        else if (stall_cnt > 0)
        begin
            out_ready <= 1'b0;
            stall_cnt <= stall_cnt - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_cnt <= gap_len();
        end
    end

    // negate, perp, add and sub at the extremes
    task automatic test_vector_ops();
        send_item(make_item(v3alu_pkg::OP_NEG, W_MIN, W_MAX, 32'sd0, 0, 0, 0, 0,
                            2'd3, 2'd0));
        send_item(make_item(v3alu_pkg::OP_NEG, W_ONE, -W_ONE, 32'sd5, 0, 0, 0, 0,
                            2'd1, 2'd0));
        send_item(make_item(v3alu_pkg::OP_PERP, W_ONE, W_MIN, W_MAX, 0, 0, 0, 0,
                            v3alu_pkg::DIM_PLANE, 2'd0));
        send_item(make_item(v3alu_pkg::OP_PERP, W_MAX, W_ONE, W_MIN, 0, 0, 0, 0,
                            v3alu_pkg::DIM_CROSS, 2'd1));
        send_item(make_item(v3alu_pkg::OP_ADD, W_MAX, W_MIN, W_ONE, W_MAX, W_MIN, -W_ONE, 0,
                            2'd1, 2'd3));
        send_item(make_item(v3alu_pkg::OP_SUB, W_MAX, W_MIN, W_ONE, W_MIN, W_MAX, W_ONE, 0,
                            2'd3, 2'd0));
    endtask

    // scale and divide, including division by zero
    task automatic test_scale_div();
        send_item(make_item(v3alu_pkg::OP_SCALE, W_MAX, W_MIN, -W_ONE, 0, 0, 0, W_MIN,
                            2'd3, 2'd0));
        send_item(make_item(v3alu_pkg::OP_SCALE, 32'sh00018000, -32'sd3, W_ONE, 0, 0, 0,
                            32'sh00008000, 2'd2, 2'd0));
        send_item(make_item(v3alu_pkg::OP_DIV, W_MAX, W_MIN, 32'sd7, 0, 0, 0, 32'sd1,
                            2'd1, 2'd0));
        send_item(make_item(v3alu_pkg::OP_DIV, -32'sd7, W_ONE, W_MIN, 0, 0, 0,
                            -32'sd3 * W_ONE, 2'd2, 2'd0));
        send_item(make_item(v3alu_pkg::OP_DIV, W_ONE, -32'sd1, 32'sd0, 0, 0, 0, 32'sd0,
                            2'd3, 2'd0));
        send_item(make_item(v3alu_pkg::OP_DIV, 32'sd0, 32'sd0, 32'sd0, 0, 0, 0, 32'sd0,
                            2'd0, 2'd0));
    endtask

    // dot, perp product and cross product
    task automatic test_products();
        send_item(make_item(v3alu_pkg::OP_DOT, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 0,
                            2'd3, 2'd3));
        send_item(make_item(v3alu_pkg::OP_DOT, -32'sd3, W_ONE, 32'sd1, 32'sd5, -W_ONE,
                            -32'sd1, 0, 2'd3, 2'd3));
        send_item(make_item(v3alu_pkg::OP_PERPPROD, W_MAX, W_MIN, 0, W_MIN, W_MAX, 0, 0,
                            v3alu_pkg::DIM_PLANE, 2'd2));
        send_item(make_item(v3alu_pkg::OP_PERPPROD, W_ONE, -32'sd1, 0, 32'sd1, W_ONE, 0, 0,
                            2'd1, 2'd2));
        send_item(make_item(v3alu_pkg::OP_CROSS, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, 0,
                            2'd0, 2'd1));
        send_item(make_item(v3alu_pkg::OP_CROSS, W_ONE, -32'sd1, 32'sd3, -32'sd7, W_ONE,
                            W_ONE, 0, 2'd3, 2'd3));
    endtask

    // normalize, the zero vector among them
    task automatic test_normalize();
        send_item(make_item(v3alu_pkg::OP_NORM, 32'sd0, 32'sd0, 32'sd0, 0, 0, 0, 0,
                            2'd1, 2'd0));
        send_item(make_item(v3alu_pkg::OP_NORM, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0,
                            2'd3, 2'd0));
        send_item(make_item(v3alu_pkg::OP_NORM, 32'sd1, 32'sd0, 32'sd0, 0, 0, 0, 0,
                            2'd2, 2'd0));
        send_item(make_item(v3alu_pkg::OP_NORM, W_MAX, -32'sd1, W_ONE, 0, 0, 0, 0,
                            2'd0, 2'd0));
    endtask

    // undefined opcodes give an all-zero result
    task automatic test_undefined();
        send_item(make_item(OP_UNDEF_LO, W_MAX, W_MIN, W_ONE, W_MAX, W_MIN, W_ONE, W_MAX,
                            2'd3, 2'd3));
        send_item(make_item(OP_UNDEF_HI, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                            -32'sd1, -32'sd1, 2'd3, 2'd3));
    endtask

    // random transactions, alternating idle and back-to-back stretches
    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 200 == 0)
                no_idle = (i % 400 != 0);
            send_item(rand_item());
        end
        no_idle = 1'b0;
    endtask

    // main sequence
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_vector_ops();
        test_scale_div();
        test_products();
        test_normalize();
        test_undefined();
        test_random(1000);
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (250) @(posedge clk);
        if (fail_cnt == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- sim.f -----
src/v3alu_pkg.sv
src/v3alu_pipe.sv
src/v3alu_div.sv
src/v3alu_sqrt.sv
src/vector3_alu_top.sv
tb/vector3_alu_top_tb.sv
